// ===== hdl/crc32_xor_parity_fec_encoder_macros.svh =====
// Assertion macros for the CRC-32 and XOR parity recovery encoder.
// Included by the top level; no other dependencies.
`ifndef CRC32_XOR_PARITY_FEC_ENCODER_MACROS_SVH
`define CRC32_XOR_PARITY_FEC_ENCODER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CFE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: %m");

// An antecedent that implies a consequent in the same cycle.
`define CFE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// An antecedent that implies a consequent in the next cycle.
`define CFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

// ===== hdl/crcfec_pkg.sv =====
// Shared constants, types and functions for the CRC-32 and parity encoder.
// No dependencies; used by the storage module and the top level.
`timescale 1ns / 1ps

package crcfec_pkg;

   localparam int unsigned BODY_LEN       = 39;
   localparam int unsigned POS_W          = $clog2(BODY_LEN);
   localparam int unsigned GROUP_SIZE_DEF = 3;

   localparam logic [POS_W-1:0] PRIO_POS     = POS_W'(BODY_LEN - 1);
   localparam logic [31:0]      CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [31:0]      CRC_POLY     = 32'hEDB8_8320;
   localparam logic [7:0]       FEC_MAGIC    = 8'hFE;
   localparam logic [7:0]       REC_PRIORITY = 8'h02;
   localparam logic [7:0]       CRITICAL     = 8'h01;

   typedef enum logic [2:0] {
      ST_IN,
      ST_CRC,
      ST_PAR,
      ST_REC_RD,
      ST_REC,
      ST_RCRC
   } state_type;

   // One byte through the reflected CRC-32, bit by bit.
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   // Header fields of the recovery packet override the parity bytes.
   function automatic logic [7:0] rec_byte(input logic [POS_W-1:0] idx, input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (idx == '0) begin
         r = FEC_MAGIC;
      end else if (idx <= POS_W'(4)) begin
         r = 8'd0;
      end else if (idx == PRIO_POS) begin
         r = REC_PRIORITY;
      end
      return r;
   endfunction

endpackage

// ===== hdl/crcfec_ram.sv =====
// Simple dual-port synchronous memory with a registered read.
// Uses crcfec_pkg for the packet length and address width.
`timescale 1ns / 1ps

module crcfec_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [crcfec_pkg::POS_W-1:0]  wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic                          rd_en,
   input  logic [crcfec_pkg::POS_W-1:0]  rd_addr,
   output logic [7:0]                    rd_data
);
   import crcfec_pkg::*;

   logic [7:0] mem [BODY_LEN];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/crc32_xor_parity_fec_encoder.sv =====
// Top level of the telemetry CRC-32 and XOR parity recovery encoder.
// Depends on crcfec_pkg, crcfec_ram and the assertion macro header.
//
// Usage:
//   The request channel (req_) carries one packet body byte per request; the
//   block counts offsets 0 to 38 itself, so every 39th byte closes a packet.
//   The response channel (rsp_) carries emitted bytes: tuser is 0 for the
//   packet's CRC bytes and 1 for recovery packet bytes; tlast marks the final
//   byte caused by one request.
//   Offsets 0 to 37 produce nothing. Offset 38 gives the four CRC bytes,
//   least significant first, through the CRC state and the output
//   register. A critical packet then costs a parity update pass in the
//   packet and parity memories, one entry per cycle. After the last critical
//   packet of a group, a read set-up state and 43 recovery bytes follow, one
//   per cycle while the receiver is ready. No request is taken from offset
//   38 until its output is done.
//   A stalled receiver holds the output register and pauses the emission.
//   Reset clears the offset and group count and presets the CRC; the memories
//   need no clearing, as each entry is written before it is read.
`timescale 1ns / 1ps
`include "crc32_xor_parity_fec_encoder_macros.svh"

module crc32_xor_parity_fec_encoder #(
   parameter int unsigned GROUP_SIZE = crcfec_pkg::GROUP_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] from_parity
   output logic       rsp_tlast    // run_end
);
   import crcfec_pkg::*;

   localparam int unsigned GC_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam logic [GC_W-1:0] GC_LAST = GC_W'(GROUP_SIZE - 1);

   state_type state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] idx_ff, idx_in;
   logic [POS_W-1:0] wr_idx_ff, wr_idx_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      crc_out_ff, crc_out_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [GC_W-1:0]  gc_ff, gc_in;
   logic             crit_ff, crit_in;
   logic             rec_ff, rec_in;
   logic             load_ff, load_in;
   logic             wr_v_ff, wr_v_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_par_ff, rsp_par_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_fire;
   logic             out_free;
   logic             emit;
   logic [7:0]       emit_byte;
   logic             emit_par;
   logic             emit_last;
   logic [31:0]      crc_nx;
   logic [7:0]       rec_v;

   logic             pkt_re;
   logic [7:0]       pkt_q;
   logic             par_re;
   logic [POS_W-1:0] par_ra;
   logic [7:0]       par_q;
   logic [7:0]       par_wd;

   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IN);

   // Packet body store: written on each request, read in the parity pass.
   assign pkt_re = (state_ff == ST_PAR);

   crcfec_ram u_pkt_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (pos_ff),
      .wr_data (req_tdata),
      .rd_en   (pkt_re),
      .rd_addr (idx_ff),
      .rd_data (pkt_q)
   );

   // Parity store: read-modify-write in the pass, read for the recovery packet.
   assign rec_v  = rec_byte(idx_ff, par_q);
   assign par_re = (state_ff == ST_PAR) || (state_ff == ST_REC_RD) ||
                   ((state_ff == ST_REC) && out_free && (idx_ff != PRIO_POS));
   assign par_ra = (state_ff == ST_REC) ? idx_ff + POS_W'(1) : idx_ff;
   assign par_wd = load_ff ? pkt_q : (pkt_q ^ par_q);

   crcfec_ram u_par_ram (
      .clock   (clock),
      .wr_en   (wr_v_ff),
      .wr_addr (wr_idx_ff),
      .wr_data (par_wd),
      .rd_en   (par_re),
      .rd_addr (par_ra),
      .rd_data (par_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IN: begin
            if (req_fire && (pos_ff == PRIO_POS)) begin
               state_in = ST_CRC;
            end
         end
         ST_CRC: begin
            if (out_free && (cnt_ff == 2'd3)) begin
               state_in = crit_ff ? ST_PAR : ST_IN;
            end
         end
         ST_PAR: begin
            if (idx_ff == PRIO_POS) begin
               state_in = rec_ff ? ST_REC_RD : ST_IN;
            end
         end
         ST_REC_RD: begin
            state_in = ST_REC;
         end
         ST_REC: begin
            if (out_free && (idx_ff == PRIO_POS)) begin
               state_in = ST_RCRC;
            end
         end
         ST_RCRC: begin
            if (out_free && (cnt_ff == 2'd3)) begin
               state_in = ST_IN;
            end
         end
         default: begin
            state_in = ST_IN;
         end
      endcase
   end

   // Datapath and emitted bytes for each state.
   always_comb begin
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      crc_in     = crc_ff;
      crc_out_in = crc_out_ff;
      cnt_in     = cnt_ff;
      gc_in      = gc_ff;
      crit_in    = crit_ff;
      rec_in     = rec_ff;
      load_in    = load_ff;
      crc_nx     = crc_ff;
      emit       = 1'b0;
      emit_byte  = crc_out_ff[7:0];
      emit_par   = 1'b0;
      emit_last  = 1'b0;
      case (state_ff)
         ST_IN: begin
            crc_nx = crc_byte(crc_ff, req_tdata);
            if (req_fire) begin
               if (pos_ff == PRIO_POS) begin
                  crc_out_in = ~crc_nx;
                  crc_in     = CRC_INIT;
                  pos_in     = '0;
                  cnt_in     = 2'd0;
                  crit_in    = (req_tdata == CRITICAL);
                  rec_in     = (req_tdata == CRITICAL) && (gc_ff == GC_LAST);
                  load_in    = (gc_ff == '0);
                  if (req_tdata == CRITICAL) begin
                     gc_in = (gc_ff == GC_LAST) ? '0 : gc_ff + GC_W'(1);
                  end
               end else begin
                  crc_in = crc_nx;
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         ST_CRC: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_last  = (cnt_ff == 2'd3) && !rec_ff;
               crc_out_in = crc_out_ff >> 8;
               cnt_in     = cnt_ff + 2'd1;
               idx_in     = '0;
            end
         end
         ST_PAR: begin
            idx_in = (idx_ff == PRIO_POS) ? '0 : idx_ff + POS_W'(1);
         end
         ST_REC_RD: begin
            idx_in = '0;
         end
         ST_REC: begin
            crc_nx    = crc_byte(crc_ff, rec_v);
            emit_byte = rec_v;
            emit_par  = 1'b1;
            if (out_free) begin
               emit = 1'b1;
               if (idx_ff == PRIO_POS) begin
                  crc_out_in = ~crc_nx;
                  crc_in     = CRC_INIT;
                  cnt_in     = 2'd0;
                  idx_in     = '0;
               end else begin
                  crc_in = crc_nx;
                  idx_in = idx_ff + POS_W'(1);
               end
            end
         end
         ST_RCRC: begin
            emit_par = 1'b1;
            if (out_free) begin
               emit       = 1'b1;
               emit_last  = (cnt_ff == 2'd3);
               crc_out_in = crc_out_ff >> 8;
               cnt_in     = cnt_ff + 2'd1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Parity write stage: each write lands in the cycle after its read in the pass.
   assign wr_v_in   = (state_ff == ST_PAR);
   assign wr_idx_in = idx_ff;

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_par_in   = rsp_par_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_par_in   = emit_par;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_par_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IN;
         pos_ff       <= '0;
         idx_ff       <= '0;
         crc_ff       <= CRC_INIT;
         cnt_ff       <= 2'd0;
         gc_ff        <= '0;
         crit_ff      <= 1'b0;
         rec_ff       <= 1'b0;
         load_ff      <= 1'b0;
         wr_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         gc_ff        <= gc_in;
         crit_ff      <= crit_in;
         rec_ff       <= rec_in;
         load_ff      <= load_in;
         wr_v_ff      <= wr_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      crc_out_ff  <= crc_out_in;
      wr_idx_ff   <= wr_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_par_ff  <= rsp_par_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Checks on the sequencing.
   `CFE_ASSERT_ALWAYS(a_pos_range, clock, reset, pos_ff <= PRIO_POS)
   `CFE_ASSERT_ALWAYS(a_gc_range, clock, reset, gc_ff <= GC_LAST)
   `CFE_ASSERT_NEXT(a_mid_packet, clock, reset, req_fire && (pos_ff != PRIO_POS), state_ff == ST_IN)
   `CFE_ASSERT_IMPLY(a_rec_only, clock, reset, (state_ff == ST_REC) || (state_ff == ST_RCRC), rec_ff && crit_ff)

endmodule
